@@ design/utf16_to_utf8_transcoder_macros.svh @@
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// same-cycle implication, masked while reset is high
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is high
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define U16U8_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/u16u8_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QPTR_W;
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic [15:0] MASK_ASCII = 16'hFF80;
  localparam logic [15:0] MASK_TWO   = 16'hF800;
  localparam logic [15:0] MASK_SURR  = 16'hFC00;
  localparam logic [15:0] SURR_ANY   = 16'hD800;
  localparam logic [15:0] SURR_HIGH  = 16'hD800;
  localparam logic [15:0] SURR_LOW   = 16'hDC00;
  localparam logic [10:0] PLANE_BASE = 11'h040;

  localparam logic [7:0] LEAD4 = 8'b1111_0000;
  localparam logic [7:0] LEAD3 = 8'b1110_0000;
  localparam logic [7:0] LEAD2 = 8'b1100_0000;
  localparam logic [7:0] CONT  = 8'b1000_0000;

  localparam logic [1:0] LAST_IDX_1 = 2'd0;
  localparam logic [1:0] LAST_IDX_2 = 2'd1;
  localparam logic [1:0] LAST_IDX_3 = 2'd2;
  localparam logic [1:0] LAST_IDX_4 = 2'd3;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            err;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

@@ design/u16u8_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [15:0] code_unit,
  input  wire logic        end_of_buffer,
  output logic             job_wr,
  output job_t             job
);

  logic [9:0]  pending_high;
  logic        pending_valid;
  logic        error_sticky;
  logic [9:0]  pending_high_next;
  logic        pending_valid_next;
  logic        error_sticky_next;
  logic [20:0] cp;
  logic        is_low;
  logic        is_surr;

  assign is_low  = (code_unit & MASK_SURR) == SURR_LOW;
  assign is_surr = (code_unit & MASK_TWO) == SURR_ANY;
  assign cp      = {({1'b0, pending_high} + PLANE_BASE), code_unit[9:0]};

  always_comb begin
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    error_sticky_next  = error_sticky;
    job_wr             = accept;
    job                = '0;
    job.err            = 1'b1;
    job.last_idx       = LAST_IDX_1;
    priority if (error_sticky) begin
      error_sticky_next = 1'b1;
    end else if (pending_valid) begin
      pending_valid_next = 1'b0;
      pending_high_next  = '0;
      if (is_low) begin
        job.err      = 1'b0;
        job.last_idx = LAST_IDX_4;
        job.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
        job.bytes[1] = CONT | {2'd0, cp[17:12]};
        job.bytes[2] = CONT | {2'd0, cp[11:6]};
        job.bytes[3] = CONT | {2'd0, cp[5:0]};
      end else begin
        error_sticky_next = 1'b1;
      end
    end else if ((code_unit & MASK_ASCII) == 16'h0000) begin
      job.err      = 1'b0;
      job.bytes[0] = code_unit[7:0];
    end else if ((code_unit & MASK_TWO) == 16'h0000) begin
      job.err      = 1'b0;
      job.last_idx = LAST_IDX_2;
      job.bytes[0] = LEAD2 | {3'd0, code_unit[10:6]};
      job.bytes[1] = CONT | {2'd0, code_unit[5:0]};
    end else if (!is_surr) begin
      job.err      = 1'b0;
      job.last_idx = LAST_IDX_3;
      job.bytes[0] = LEAD3 | {4'd0, code_unit[15:12]};
      job.bytes[1] = CONT | {2'd0, code_unit[11:6]};
      job.bytes[2] = CONT | {2'd0, code_unit[5:0]};
    end else if (is_low || end_of_buffer) begin
      error_sticky_next = 1'b1;
    end else begin
      job_wr             = 1'b0;
      pending_valid_next = 1'b1;
      pending_high_next  = code_unit[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      pending_valid <= 1'b0;
      error_sticky  <= 1'b0;
    end else if (accept) begin
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      error_sticky  <= error_sticky_next;
    end
  end

endmodule

`default_nettype wire

@@ design/u16u8_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue
  import u16u8_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_job,
  input  wire logic rd,
  output job_t      head,
  output q_status_t status
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign status.empty = count == '0;
  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/u16u8_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire job_t      head,
  input  wire q_status_t status,
  output logic           rd,
  input  wire logic      pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           last_byte,
  output logic           error
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !out_valid || pop;
  assign at_last = idx == head.last_idx;
  assign rd      = load && !status.empty && at_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !status.empty;
      if (!status.empty) begin
        idx <= at_last ? 2'd0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !status.empty) begin
      out_byte  <= head.bytes[idx];
      last_byte <= at_last;
      error     <= head.err;
    end
  end

endmodule

`default_nettype wire

@@ design/utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                   | transaction at rising edge
// input   | push, full, code_unit, end_of_buffer      | push && !full
// result  | empty, pop, out_byte, last_byte, error    | pop && !empty
//
// One result byte per cycle while pop stays high; a code unit gives 1 to 4 result
// bytes by its UTF-8 length, a held high surrogate none. The byte serializer sets
// the rate. The first byte passes through the job queue and the output register.
// Reset clears the held surrogate, the sticky error, the 4-entry job queue and
// the output valid flag. full rises when four jobs wait, behind a stalled pop or
// behind multibyte units that the serializer has not yet sent.

module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] code_unit,
  input  wire logic        end_of_buffer,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             error
);

  job_t      job;
  job_t      head;
  logic      job_wr;
  logic      q_rd;
  logic      accept;
  q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  u16u8_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .code_unit     (code_unit),
    .end_of_buffer (end_of_buffer),
    .job_wr        (job_wr),
    .job           (job)
  );

  u16u8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_wr),
    .wr_job (job),
    .rd     (q_rd),
    .head   (head),
    .status (q_status)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (q_status),
    .rd        (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .error     (error)
  );

endmodule

`default_nettype wire

@@ design/u16u8_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic [15:0] code_unit,
  input wire logic        end_of_buffer,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  out_byte,
  input wire logic        last_byte,
  input wire logic        error
);

  logic unused_in;
  assign unused_in = push ^ end_of_buffer ^ (^code_unit);

  `U16U8_ASSERT_RST(a_reset_clears, rst, empty && !full, "reset left data or full set")
  `U16U8_ASSERT_NOW(a_err_form, !empty && error, out_byte == 8'h00 && last_byte, "bad error result")
  `U16U8_ASSERT_NOW(a_mid_byte, !empty && !error && !last_byte, out_byte[7], "mid byte not multibyte")
  `U16U8_ASSERT_NOW(a_end_byte, !empty && !error && last_byte, out_byte[7:6] != 2'b11, "lead byte ends unit")
  `U16U8_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte), "result dropped on stall")

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import u16u8_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned STALL_CYCLES = 60;

  typedef struct {
    logic [15:0] unit;
    logic        eob;
  } unit_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       err;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] code_unit = 16'h0000;
  logic        end_of_buffer = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        error;

  unit_item_t  unit_queue[$];
  utf8_byte_t  utf8_due[$];
  unit_item_t  next_unit;
  utf8_byte_t  due_head;

  logic [9:0]  held_hi = '0;
  logic        held_valid = 1'b0;
  logic        sticky_err = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_ack = 0;
  int unsigned stall_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  utf16_to_utf8_transcoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .code_unit     (code_unit),
    .end_of_buffer (end_of_buffer),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .last_byte     (last_byte),
    .error         (error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic due_byte(input logic [7:0] value, input logic last, input logic err);
    utf8_byte_t b;
    b.value = value;
    b.last  = last;
    b.err   = err;
    utf8_due.push_back(b);
  endtask

  task automatic encode_unit(input logic [15:0] u, input logic eob);
    logic [20:0] cp;
    if (sticky_err || (held_valid && (u & MASK_SURR) != SURR_LOW) ||
        (!held_valid && (u & MASK_SURR) == SURR_LOW) ||
        (!held_valid && (u & MASK_SURR) == SURR_HIGH && eob)) begin
      sticky_err = 1'b1;
      held_valid = 1'b0;
      held_hi    = '0;
      due_byte(8'h00, 1'b1, 1'b1);
    end else if (held_valid) begin
      cp = ({11'd0, held_hi} << 10) + {11'd0, u[9:0]} + 21'h10000;
      held_valid = 1'b0;
      held_hi    = '0;
      due_byte(LEAD4 | {5'd0, cp[20:18]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, cp[17:12]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, cp[11:6]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
    end else if ((u & MASK_ASCII) == 16'h0000) begin
      due_byte(u[7:0], 1'b1, 1'b0);
    end else if ((u & MASK_TWO) == 16'h0000) begin
      due_byte(LEAD2 | {3'd0, u[10:6]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, u[5:0]}, 1'b1, 1'b0);
    end else if ((u & MASK_TWO) != SURR_ANY) begin
      due_byte(LEAD3 | {4'd0, u[15:12]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, u[11:6]}, 1'b0, 1'b0);
      due_byte(CONT | {2'd0, u[5:0]}, 1'b1, 1'b0);
    end else begin
      held_hi    = u[9:0];
      held_valid = 1'b1;
    end
  endtask

  // driver: hold while full, else offer the next pending unit
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_unit(code_unit, end_of_buffer);
      end
      if (push && full) begin
      end else if (unit_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_unit = unit_queue.pop_front();
        push          <= 1'b1;
        code_unit     <= next_unit.unit;
        end_of_buffer <= next_unit.eob;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: check each result transaction against the oldest due byte
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (utf8_due.size() == 0) begin
          $display("%0t: unexpected result out_byte %h last_byte %b error %b",
                   $time, out_byte, last_byte, error);
          mismatch_cnt++;
        end else begin
          due_head = utf8_due.pop_front();
          if (out_byte !== due_head.value) begin
            $display("%0t: out_byte expected %h actual %h", $time, due_head.value, out_byte);
            mismatch_cnt++;
          end
          if (last_byte !== due_head.last) begin
            $display("%0t: last_byte expected %b actual %b", $time, due_head.last, last_byte);
            mismatch_cnt++;
          end
          if (error !== due_head.err) begin
            $display("%0t: error expected %b actual %b", $time, due_head.err, error);
            mismatch_cnt++;
          end
        end
      end
      if (stall_ack != stall_req) begin
        stall_ack  <= stall_req;
        stall_left <= STALL_CYCLES;
        pop        <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_unit(input logic [15:0] unit, input logic eob);
    unit_item_t it;
    it.unit = unit;
    it.eob  = eob;
    unit_queue.push_back(it);
  endtask

  function automatic logic [15:0] rand_bmp();
    logic [15:0] u;
    case ($urandom_range(0, 3))
      0: u = 16'($urandom_range(0, 16'h007F));
      1: u = 16'($urandom_range(16'h0080, 16'h07FF));
      2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
      default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
    return u;
  endfunction

  // well-formed text: non-surrogates and complete surrogate pairs
  task automatic add_text(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_unit(SURR_HIGH | 16'($urandom_range(0, 1023)), 1'b0);
        add_unit(SURR_LOW | 16'($urandom_range(0, 1023)), $urandom_range(0, 7) == 0);
      end else begin
        add_unit(rand_bmp(), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic drain();
    while (unit_queue.size() != 0 || push || utf8_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] u;
    int          kind;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 75;
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b1);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hDE00, 1'b0);
    add_unit(16'h0041, 1'b1);
    add_unit(16'h5555, 1'b0);
    add_unit(16'hAAAA, 1'b0);
    add_text(60);
    drain();

    // block the result side so the job queue fills and full rises
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = stall_req + 1;
    for (int i = 0; i < 24; i++) add_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 28;
    add_text(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_text(50);
    kind = $urandom_range(0, 2);
    case (kind)
      0: add_unit(SURR_LOW | 16'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      1: begin
        add_unit(SURR_HIGH | 16'($urandom_range(0, 1023)), 1'b0);
        u = ($urandom_range(0, 1) != 0) ? rand_bmp() : (SURR_HIGH | 16'($urandom_range(0, 1023)));
        add_unit(u, 1'($urandom_range(0, 1)));
      end
      default: add_unit(SURR_HIGH | 16'($urandom_range(0, 1023)), 1'b1);
    endcase
    for (int i = 0; i < 8; i++) begin
      add_unit(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    drain();

    repeat (12) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_transcoder.sv
design/u16u8_checker.sv
verif/tb.sv
